### hdl/csrd_pkg.sv
// Package for the client/server request dispatcher.
// Holds request codes, log codes, register indexes and the decoded config type.
// No dependencies.
package csrd_pkg;

    localparam int CAP_W = 9;   // holds any capacity up to a depth of 256

    localparam logic [1:0] REQ_ADD       = 2'd0;
    localparam logic [1:0] REQ_INTERRUPT = 2'd1;
    localparam logic [1:0] REQ_SEND      = 2'd2;
    localparam logic [1:0] REQ_OPERATE   = 2'd3;

    localparam logic [7:0] LOG_QFULL = 8'h31;
    localparam logic [7:0] LOG_SFULL = 8'h32;
    localparam logic [7:0] LOG_EMPTY = 8'h33;

    localparam logic [2:0] CFG_CLIENT_COUNT = 3'd0;
    localparam logic [2:0] CFG_CLIENT_QCAP  = 3'd1;
    localparam logic [2:0] CFG_CLIENT_SCAP  = 3'd2;
    localparam logic [2:0] CFG_SERVER_QCAP  = 3'd3;
    localparam logic [2:0] CFG_SERVER_SCAP  = 3'd4;

    typedef struct packed {
        logic [4:0]       nc;   // clients in use, server is nc + 1
        logic [CAP_W-1:0] cq;
        logic [CAP_W-1:0] cs;
        logic [CAP_W-1:0] sq;
        logic [CAP_W-1:0] ss;
    } cfg_eff_t;

endpackage

### hdl/client_server_request_dispatcher_core.sv
// Client/server request dispatcher: capture, memory read, execute and, for a request that logs, output per request.
// The first log entry is valid once the accepted request has passed the read and execute states.
// A new request is taken only in the idle state, after every log entry of the last one has
// been taken by the output, so an output stall holds the input as well.
// Reset restores the register defaults and clears pointers and counts, not the byte memories.
// Depends on csrd_pkg and csrd_cfg.
module client_server_request_dispatcher_core
    import csrd_pkg::*;
#(
    parameter int MAX_CLIENTS = 8,
    parameter int FIFO_DEPTH  = 16,
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // machine_id[3:0], item_char[11:4], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // log_machine[3:0], log_value[11:4], zero pad
    output logic        m_axis_tlast
);

    localparam int CW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int FAW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FCW   = $clog2(FIFO_DEPTH + 1);
    localparam int SCW   = $clog2(STACK_DEPTH + 1);
    localparam int FSW   = FCW + 1;
    localparam int CFAW  = (MAX_CLIENTS * FIFO_DEPTH > 1) ?
                           $clog2(MAX_CLIENTS * FIFO_DEPTH) : 1;
    localparam int CSAW  = (MAX_CLIENTS * STACK_DEPTH > 1) ?
                           $clog2(MAX_CLIENTS * STACK_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_OUT} state_t;

    cfg_eff_t cfg;

    csrd_cfg #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Byte memories
    logic [7:0] client_fifo_mem  [MAX_CLIENTS*FIFO_DEPTH];
    logic [7:0] client_stack_mem [MAX_CLIENTS*STACK_DEPTH];
    logic [7:0] server_fifo_mem  [FIFO_DEPTH];
    logic [7:0] server_stack_mem [STACK_DEPTH];

    // Pointers and occupancies
    logic [FAW-1:0] cf_head_reg  [MAX_CLIENTS];
    logic [FCW-1:0] cf_count_reg [MAX_CLIENTS];
    logic [SCW-1:0] cs_count_reg [MAX_CLIENTS];
    logic [FAW-1:0] sf_head_reg;
    logic [FCW-1:0] sf_count_reg;
    logic [SCW-1:0] ss_count_reg;

    state_t         state_reg;
    logic [1:0]     type_reg;
    logic [3:0]     id_reg;
    logic [7:0]     ch_reg;
    logic [7:0]     cf_rd_reg;
    logic [7:0]     cs_rd_reg;
    logic [7:0]     sf_rd_reg;
    logic [7:0]     ss_rd_reg;
    logic [3:0]     res_mach_reg [2];
    logic [7:0]     res_val_reg  [2];
    logic           res_two_reg;
    logic           sel_reg;

    // Request decode
    logic           is_client;
    logic           is_server;
    logic [CW-1:0]  c_idx;
    logic [4:0]     srv;
    logic [FAW-1:0] cf_head;
    logic [FCW-1:0] cf_cnt;
    logic [SCW-1:0] cs_cnt;

    always_comb
    begin
        srv       = cfg.nc + 5'd1;
        is_client = (id_reg != 4'd0) && ({1'b0, id_reg} <= cfg.nc);
        is_server = ({1'b0, id_reg} == srv);
        c_idx     = is_client ? CW'(id_reg - 4'd1) : '0;
        cf_head   = cf_head_reg[c_idx];
        cf_cnt    = cf_count_reg[c_idx];
        cs_cnt    = cs_count_reg[c_idx];
    end

    // Read addresses
    logic [CFAW-1:0] cf_rd_addr;
    logic [CSAW-1:0] cs_rd_addr;
    logic [SAW-1:0]  ss_rd_addr;

    assign cf_rd_addr = CFAW'(c_idx) * CFAW'(FIFO_DEPTH) + CFAW'(cf_head);
    assign cs_rd_addr = CSAW'(c_idx) * CSAW'(STACK_DEPTH) + CSAW'(SAW'(cs_cnt - SCW'(1)));
    assign ss_rd_addr = SAW'(ss_count_reg - SCW'(1));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            cf_rd_reg <= client_fifo_mem[cf_rd_addr];
            cs_rd_reg <= client_stack_mem[cs_rd_addr];
            sf_rd_reg <= server_fifo_mem[sf_head_reg];
            ss_rd_reg <= server_stack_mem[ss_rd_addr];
        end
    end

    // Execute step
    logic [FSW-1:0]  cf_sum;
    logic [FSW-1:0]  sf_sum;
    logic [FAW-1:0]  cf_tail;
    logic [FAW-1:0]  sf_tail;
    logic [FAW-1:0]  cf_head_inc;
    logic [FAW-1:0]  sf_head_inc;
    logic            cf_we;
    logic            cs_we;
    logic            sf_we;
    logic            ss_we;
    logic [CFAW-1:0] cf_waddr;
    logic [CSAW-1:0] cs_waddr;
    logic [7:0]      sf_wdata;
    logic [FAW-1:0]  cf_head_next;
    logic [FCW-1:0]  cf_cnt_next;
    logic [SCW-1:0]  cs_cnt_next;
    logic [FAW-1:0]  sf_head_next;
    logic [FCW-1:0]  sf_cnt_next;
    logic [SCW-1:0]  ss_cnt_next;
    logic [1:0]      res_n;
    logic [3:0]      r0_mach;
    logic [7:0]      r0_val;
    logic [3:0]      r1_mach;
    logic [7:0]      r1_val;
    logic            served;
    logic [7:0]      served_val;

    always_comb
    begin
        cf_sum      = FSW'(cf_head) + FSW'(cf_cnt);
        sf_sum      = FSW'(sf_head_reg) + FSW'(sf_count_reg);
        cf_tail     = (cf_sum >= FSW'(FIFO_DEPTH)) ? FAW'(cf_sum - FSW'(FIFO_DEPTH))
                                                    : FAW'(cf_sum);
        sf_tail     = (sf_sum >= FSW'(FIFO_DEPTH)) ? FAW'(sf_sum - FSW'(FIFO_DEPTH))
                                                    : FAW'(sf_sum);
        cf_head_inc = (cf_head == FAW'(FIFO_DEPTH - 1)) ? '0 : cf_head + FAW'(1);
        sf_head_inc = (sf_head_reg == FAW'(FIFO_DEPTH - 1)) ? '0 : sf_head_reg + FAW'(1);
        cf_waddr    = CFAW'(c_idx) * CFAW'(FIFO_DEPTH) + CFAW'(cf_tail);
        cs_waddr    = CSAW'(c_idx) * CSAW'(STACK_DEPTH) + CSAW'(SAW'(cs_cnt));

        cf_we        = 1'b0;
        cs_we        = 1'b0;
        sf_we        = 1'b0;
        ss_we        = 1'b0;
        sf_wdata     = ch_reg;
        cf_head_next = cf_head;
        cf_cnt_next  = cf_cnt;
        cs_cnt_next  = cs_cnt;
        sf_head_next = sf_head_reg;
        sf_cnt_next  = sf_count_reg;
        ss_cnt_next  = ss_count_reg;
        res_n        = 2'd0;
        r0_mach      = id_reg;
        r0_val       = LOG_EMPTY;
        r1_mach      = 4'(srv);
        r1_val       = LOG_QFULL;
        served       = 1'b0;
        served_val   = cs_rd_reg;

        case (type_reg)
            REQ_ADD:
            begin
                if (is_client)
                begin
                    if (CAP_W'(cf_cnt) >= cfg.cq)
                    begin
                        res_n  = 2'd1;
                        r0_val = LOG_QFULL;
                    end
                    else
                    begin
                        cf_we       = 1'b1;
                        cf_cnt_next = cf_cnt + FCW'(1);
                    end
                end
            end
            REQ_INTERRUPT:
            begin
                if (is_client)
                begin
                    if (CAP_W'(cs_cnt) >= cfg.cs)
                    begin
                        res_n  = 2'd1;
                        r0_val = LOG_SFULL;
                    end
                    else
                    begin
                        cs_we       = 1'b1;
                        cs_cnt_next = cs_cnt + SCW'(1);
                    end
                end
                else if (is_server)
                begin
                    if (CAP_W'(ss_count_reg) >= cfg.ss)
                    begin
                        res_n   = 2'd1;
                        r0_mach = 4'(srv);
                        r0_val  = LOG_SFULL;
                    end
                    else
                    begin
                        ss_we       = 1'b1;
                        ss_cnt_next = ss_count_reg + SCW'(1);
                    end
                end
            end
            REQ_SEND:
            begin
                if (is_client)
                begin
                    // Interrupts take precedence over queued processes
                    if (cs_cnt != '0)
                    begin
                        served      = 1'b1;
                        served_val  = cs_rd_reg;
                        cs_cnt_next = cs_cnt - SCW'(1);
                    end
                    else if (cf_cnt != '0)
                    begin
                        served       = 1'b1;
                        served_val   = cf_rd_reg;
                        cf_head_next = cf_head_inc;
                        cf_cnt_next  = cf_cnt - FCW'(1);
                    end
                    res_n  = 2'd1;
                    r0_val = served ? served_val : LOG_EMPTY;
                    if (served)
                    begin
                        sf_wdata = served_val;
                        if (CAP_W'(sf_count_reg) >= cfg.sq)
                            res_n = 2'd2;   // drop the byte, log on the server
                        else
                        begin
                            sf_we       = 1'b1;
                            sf_cnt_next = sf_count_reg + FCW'(1);
                        end
                    end
                end
            end
            REQ_OPERATE:
            begin
                res_n   = 2'd1;
                r0_mach = 4'(srv);
                if (ss_count_reg != '0)
                begin
                    r0_val      = ss_rd_reg;
                    ss_cnt_next = ss_count_reg - SCW'(1);
                end
                else if (sf_count_reg != '0)
                begin
                    r0_val       = sf_rd_reg;
                    sf_head_next = sf_head_inc;
                    sf_cnt_next  = sf_count_reg - FCW'(1);
                end
                else
                    r0_val = LOG_EMPTY;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            if (cf_we)
                client_fifo_mem[cf_waddr] <= ch_reg;
            if (cs_we)
                client_stack_mem[cs_waddr] <= ch_reg;
            if (sf_we)
                server_fifo_mem[sf_tail] <= sf_wdata;
            if (ss_we)
                server_stack_mem[SAW'(ss_count_reg)] <= ch_reg;
        end
    end

    // Sequencer, pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sf_head_reg     <= '0;
            sf_count_reg    <= '0;
            ss_count_reg    <= '0;
            res_two_reg     <= 1'b0;
            sel_reg         <= 1'b0;
            res_mach_reg[0] <= '0;
            res_val_reg[0]  <= '0;
            res_mach_reg[1] <= '0;
            res_val_reg[1]  <= '0;
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                cf_head_reg[i]  <= '0;
                cf_count_reg[i] <= '0;
                cs_count_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    cf_head_reg[c_idx]  <= cf_head_next;
                    cf_count_reg[c_idx] <= cf_cnt_next;
                    cs_count_reg[c_idx] <= cs_cnt_next;
                    sf_head_reg         <= sf_head_next;
                    sf_count_reg        <= sf_cnt_next;
                    ss_count_reg        <= ss_cnt_next;
                    res_mach_reg[0]     <= r0_mach;
                    res_val_reg[0]      <= r0_val;
                    res_mach_reg[1]     <= r1_mach;
                    res_val_reg[1]      <= r1_val;
                    res_two_reg         <= (res_n == 2'd2);
                    sel_reg             <= 1'b0;
                    state_reg           <= (res_n == 2'd0) ? S_IDLE : S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (res_two_reg && !sel_reg)
                            sel_reg <= 1'b1;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            type_reg <= s_axis_tuser;
            id_reg   <= s_axis_tdata[3:0];
            ch_reg   <= s_axis_tdata[11:4];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, res_val_reg[sel_reg], res_mach_reg[sel_reg]};
    assign m_axis_tlast  = !res_two_reg || sel_reg;

endmodule

### hdl/csrd_cfg.sv
// Configuration registers of the dispatcher and their clamped values.
// Depends on csrd_pkg.
module csrd_cfg
    import csrd_pkg::*;
#(
    parameter int MAX_CLIENTS = 8,
    parameter int FIFO_DEPTH  = 16,
    parameter int STACK_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data,
    output cfg_eff_t   cfg
);

    logic [3:0] client_count_reg;
    logic [4:0] cq_reg;
    logic [4:0] cs_reg;
    logic [4:0] sq_reg;
    logic [4:0] ss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_count_reg <= 4'd1;
            cq_reg           <= 5'd16;
            cs_reg           <= 5'd16;
            sq_reg           <= 5'd16;
            ss_reg           <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIENT_COUNT: client_count_reg <= cfg_data[3:0];
                CFG_CLIENT_QCAP:  cq_reg           <= cfg_data;
                CFG_CLIENT_SCAP:  cs_reg           <= cfg_data;
                CFG_SERVER_QCAP:  sq_reg           <= cfg_data;
                CFG_SERVER_SCAP:  ss_reg           <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate capacities at the physical depth, zero stays always full.
    always_comb
    begin
        if (client_count_reg == 4'd0)
            cfg.nc = 5'd1;
        else if (32'(client_count_reg) > MAX_CLIENTS)
            cfg.nc = 5'(MAX_CLIENTS);
        else
            cfg.nc = {1'b0, client_count_reg};
        cfg.cq = (32'(cq_reg) > FIFO_DEPTH)  ? CAP_W'(FIFO_DEPTH)  : CAP_W'(cq_reg);
        cfg.cs = (32'(cs_reg) > STACK_DEPTH) ? CAP_W'(STACK_DEPTH) : CAP_W'(cs_reg);
        cfg.sq = (32'(sq_reg) > FIFO_DEPTH)  ? CAP_W'(FIFO_DEPTH)  : CAP_W'(sq_reg);
        cfg.ss = (32'(ss_reg) > STACK_DEPTH) ? CAP_W'(STACK_DEPTH) : CAP_W'(ss_reg);
    end

endmodule

### test/client_server_request_dispatcher_core_tb.sv
// Self-checking testbench for client_server_request_dispatcher_core.
// Drives request streams through several register settings and checks each log entry
// against a behavioral predictor. Depends on csrd_pkg and the core RTL.
`timescale 1ns / 1ps

module client_server_request_dispatcher_core_tb
    import csrd_pkg::*;
();

    localparam int MAX_CL          = 8;
    localparam int DEPTH           = 16;
    localparam int PHASES          = 8;
    localparam int PHASE_REQUESTS  = 100;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [3:0] mach;
        logic [7:0] val;
        logic       last;
    } log_entry_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] id;
        logic [7:0] ch;
        logic       typed;
        logic [3:0] t_mach;
        logic [7:0] t_val;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // machine_id[3:0], item_char[11:4], zero pad
    logic [1:0]  s_axis_tuser;     // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // log_machine[3:0], log_value[11:4], zero pad
    logic        m_axis_tlast;

    // predictor copy of the configuration and stores
    logic [3:0] cfg_clients;
    logic [4:0] cfg_cq;
    logic [4:0] cfg_cs;
    logic [4:0] cfg_sq;
    logic [4:0] cfg_ss;
    logic [7:0] cl_fifo  [MAX_CL][DEPTH];
    int         cl_head  [MAX_CL];
    int         cl_qcnt  [MAX_CL];
    logic [7:0] cl_stack [MAX_CL][DEPTH];
    int         cl_scnt  [MAX_CL];
    logic [7:0] srv_fifo  [DEPTH];
    int         srv_head;
    int         srv_qcnt;
    logic [7:0] srv_stack [DEPTH];
    int         srv_scnt;

    log_entry_t model_out [2];
    int         model_n;
    log_entry_t pending_logs [$];
    int         mismatch_count;
    bit         quiet_phase;
    bit         hold_off_pending;

    client_server_request_dispatcher_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // mostly short gaps, a few long ones, none at all in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clients_in_use();
        if (cfg_clients == 4'd0)
            return 1;
        if (cfg_clients > MAX_CL)
            return MAX_CL;
        return int'(cfg_clients);
    endfunction

    function automatic int clamp_depth(input logic [4:0] cap);
        return (cap > DEPTH) ? DEPTH : int'(cap);
    endfunction

    function automatic bit request_ignored(input logic [1:0] kind, input logic [3:0] id);
        int nc;
        nc = clients_in_use();
        if (kind == REQ_ADD || kind == REQ_SEND)
            return !(id >= 1 && id <= nc);
        if (kind == REQ_INTERRUPT)
            return !(id >= 1 && id <= nc + 1);
        return 1'b0;
    endfunction

    task automatic note_log(input logic [3:0] mach, input logic [7:0] val);
        model_out[model_n].mach = mach;
        model_out[model_n].val  = val;
        model_out[model_n].last = 1'b0;
        model_n++;
    endtask

    // work out the log entries of one request and advance the predicted stores
    task automatic dispatch_model(input logic [1:0] kind, input logic [3:0] id,
                                  input logic [7:0] ch);
        int         nc;
        int         srv;
        int         c;
        bit         is_client;
        bit         served;
        logic [7:0] v;
        model_n   = 0;
        nc        = clients_in_use();
        srv       = nc + 1;
        is_client = (id >= 1) && (id <= nc);
        c         = is_client ? int'(id) - 1 : 0;
        served    = 1'b0;
        v         = 8'h00;
        case (kind)
            REQ_ADD:
            begin
                if (is_client)
                begin
                    if (cl_qcnt[c] >= clamp_depth(cfg_cq))
                        note_log(id, LOG_QFULL);
                    else
                    begin
                        cl_fifo[c][(cl_head[c] + cl_qcnt[c]) % DEPTH] = ch;
                        cl_qcnt[c]++;
                    end
                end
            end
            REQ_INTERRUPT:
            begin
                if (is_client)
                begin
                    if (cl_scnt[c] >= clamp_depth(cfg_cs))
                        note_log(id, LOG_SFULL);
                    else
                    begin
                        cl_stack[c][cl_scnt[c]] = ch;
                        cl_scnt[c]++;
                    end
                end
                else if (id == srv)
                begin
                    if (srv_scnt >= clamp_depth(cfg_ss))
                        note_log(srv[3:0], LOG_SFULL);
                    else
                    begin
                        srv_stack[srv_scnt] = ch;
                        srv_scnt++;
                    end
                end
            end
            REQ_SEND:
            begin
                if (is_client)
                begin
                    // interrupts win over queued processes
                    if (cl_scnt[c] > 0)
                    begin
                        cl_scnt[c]--;
                        v      = cl_stack[c][cl_scnt[c]];
                        served = 1'b1;
                    end
                    else if (cl_qcnt[c] > 0)
                    begin
                        v          = cl_fifo[c][cl_head[c]];
                        cl_head[c] = (cl_head[c] + 1) % DEPTH;
                        cl_qcnt[c]--;
                        served     = 1'b1;
                    end
                    else
                        note_log(id, LOG_EMPTY);
                    if (served)
                    begin
                        note_log(id, v);
                        if (srv_qcnt >= clamp_depth(cfg_sq))
                            note_log(srv[3:0], LOG_QFULL);
                        else
                        begin
                            srv_fifo[(srv_head + srv_qcnt) % DEPTH] = v;
                            srv_qcnt++;
                        end
                    end
                end
            end
            default:
            begin
                if (srv_scnt > 0)
                begin
                    srv_scnt--;
                    v = srv_stack[srv_scnt];
                end
                else if (srv_qcnt > 0)
                begin
                    v        = srv_fifo[srv_head];
                    srv_head = (srv_head + 1) % DEPTH;
                    srv_qcnt--;
                end
                else
                    v = LOG_EMPTY;
                note_log(srv[3:0], v);
            end
        endcase
        if (model_n > 0)
            model_out[model_n - 1].last = 1'b1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_CLIENT_COUNT: cfg_clients = val[3:0];
            CFG_CLIENT_QCAP:  cfg_cq = val;
            CFG_CLIENT_SCAP:  cfg_cs = val;
            CFG_SERVER_QCAP:  cfg_sq = val;
            CFG_SERVER_SCAP:  cfg_ss = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [4:0] nc, input logic [4:0] cq,
                                input logic [4:0] cs, input logic [4:0] sq,
                                input logic [4:0] ss);
        write_reg(CFG_CLIENT_COUNT, nc);
        write_reg(CFG_CLIENT_QCAP, cq);
        write_reg(CFG_CLIENT_SCAP, cs);
        write_reg(CFG_SERVER_QCAP, sq);
        write_reg(CFG_SERVER_SCAP, ss);
        cfg_we <= 1'b0;
    endtask

    // offer one request; a typed row replaces the predicted entry with its own
    task automatic send_request(input logic [1:0] kind, input logic [3:0] id,
                                input logic [7:0] ch, input bit typed,
                                input logic [3:0] t_mach, input logic [7:0] t_val);
        int         gap;
        log_entry_t fixed;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, ch, id};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        dispatch_model(kind, id, ch);
        if (typed)
        begin
            fixed.mach = t_mach;
            fixed.val  = t_val;
            fixed.last = 1'b1;
            pending_logs.push_back(fixed);
        end
        else
        begin
            for (int k = 0; k < model_n; k++)
                pending_logs.push_back(model_out[k]);
        end
    endtask

    task automatic wait_idle();
        while (pending_logs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : log_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : log_check
        log_entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_logs.size() == 0)
                report_mismatch($sformatf("unexpected log entry mach=%0d val=%02h",
                                          m_axis_tdata[3:0], m_axis_tdata[11:4]));
            else
            begin
                want = pending_logs.pop_front();
                if (m_axis_tdata[3:0] !== want.mach)
                    report_mismatch($sformatf("log_machine got %0d want %0d",
                                              m_axis_tdata[3:0], want.mach));
                if (m_axis_tdata[11:4] !== want.val)
                    report_mismatch($sformatf("log_value got %02h want %02h",
                                              m_axis_tdata[11:4], want.val));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast got %b want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin : stimulus
        directed_row_t rows [25];
        logic [4:0]    phase_cfg [PHASES][5];
        logic [1:0]    kind;
        logic [3:0]    id;
        logic [7:0]    ch;
        int            counted;
        int            r;
        int            nc_now;
        int            drain_pct;

        // two clients, all capacities one; the server is machine 3
        rows = '{
            '{REQ_OPERATE,   4'd3,  8'h00, 1'b1, 4'd3, LOG_EMPTY},
            '{REQ_SEND,      4'd1,  8'h00, 1'b1, 4'd1, LOG_EMPTY},
            '{REQ_ADD,       4'd1,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_ADD,       4'd1,  8'hFF, 1'b1, 4'd1, LOG_QFULL},
            '{REQ_INTERRUPT, 4'd1,  8'hA5, 1'b0, 4'd0, 8'h00},
            '{REQ_INTERRUPT, 4'd1,  8'h5A, 1'b1, 4'd1, LOG_SFULL},
            '{REQ_INTERRUPT, 4'd3,  8'h3C, 1'b0, 4'd0, 8'h00},
            '{REQ_INTERRUPT, 4'd3,  8'hC3, 1'b1, 4'd3, LOG_SFULL},
            '{REQ_SEND,      4'd1,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_SEND,      4'd1,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_OPERATE,   4'd3,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_OPERATE,   4'd3,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_ADD,       4'd0,  8'h11, 1'b0, 4'd0, 8'h00},
            '{REQ_ADD,       4'd3,  8'h22, 1'b0, 4'd0, 8'h00},
            '{REQ_ADD,       4'd15, 8'h33, 1'b0, 4'd0, 8'h00},
            '{REQ_SEND,      4'd0,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_SEND,      4'd15, 8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_INTERRUPT, 4'd4,  8'h44, 1'b0, 4'd0, 8'h00},
            '{REQ_INTERRUPT, 4'd0,  8'h55, 1'b0, 4'd0, 8'h00},
            '{REQ_OPERATE,   4'd15, 8'hFF, 1'b1, 4'd3, LOG_EMPTY},
            '{REQ_ADD,       4'd2,  8'h80, 1'b0, 4'd0, 8'h00},
            '{REQ_SEND,      4'd2,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_INTERRUPT, 4'd2,  8'h7E, 1'b0, 4'd0, 8'h00},
            '{REQ_SEND,      4'd2,  8'h00, 1'b0, 4'd0, 8'h00},
            '{REQ_OPERATE,   4'd3,  8'h00, 1'b0, 4'd0, 8'h00}
        };

        phase_cfg[0] = '{5'd8, 5'd16, 5'd16, 5'd16, 5'd16};
        phase_cfg[1] = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
        phase_cfg[2] = '{5'd15, 5'd31, 5'd31, 5'd31, 5'd31};
        phase_cfg[3] = '{5'd3, 5'd4, 5'd2, 5'd3, 5'd2};
        phase_cfg[4] = '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
        for (int p = 5; p < PHASES; p++)
        begin
            phase_cfg[p][0] = 5'($urandom_range(1, MAX_CL));
            for (int j = 1; j < 5; j++)
                phase_cfg[p][j] = 5'($urandom_range(1, 20));
        end

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_CLIENT_COUNT;
        cfg_data         = 5'd0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = 16'h0000;
        s_axis_tuser     = REQ_ADD;
        mismatch_count   = 0;
        quiet_phase      = 1'b0;
        hold_off_pending = 1'b0;
        cfg_clients      = 4'd1;
        cfg_cq           = 5'd16;
        cfg_cs           = 5'd16;
        cfg_sq           = 5'd16;
        cfg_ss           = 5'd16;
        for (int i = 0; i < MAX_CL; i++)
        begin
            cl_head[i] = 0;
            cl_qcnt[i] = 0;
            cl_scnt[i] = 0;
        end
        srv_head = 0;
        srv_qcnt = 0;
        srv_scnt = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(5'd2, 5'd1, 5'd1, 5'd1, 5'd1);
        foreach (rows[i])
            send_request(rows[i].kind, rows[i].id, rows[i].ch, rows[i].typed,
                         rows[i].t_mach, rows[i].t_val);
        s_axis_tvalid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                         phase_cfg[p][3], phase_cfg[p][4]);
            quiet_phase = (p == 3) || (p == 6);
            // back up the log stream so the input side has to stall
            if (p == 2)
                hold_off_pending = 1'b1;
            drain_pct = $urandom_range(5, 30);
            nc_now    = clients_in_use();
            counted   = 0;
            while (counted < PHASE_REQUESTS)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    kind = 2'($urandom_range(0, 3));
                    id   = 4'($urandom_range(0, 15));
                end
                else if (r < 5 + drain_pct)
                begin
                    kind = REQ_OPERATE;
                    id   = 4'($urandom_range(0, 15));
                end
                else
                begin
                    r  = $urandom_range(0, 2);
                    id = 4'($urandom_range(1, nc_now));
                    if (r == 0)
                        kind = REQ_ADD;
                    else if (r == 1)
                        kind = REQ_INTERRUPT;
                    else
                        kind = REQ_SEND;
                    if (kind == REQ_INTERRUPT && $urandom_range(0, 3) == 0)
                        id = 4'(nc_now + 1);
                end
                ch = 8'($urandom_range(0, 255));
                if (!request_ignored(kind, id))
                    counted++;
                send_request(kind, id, ch, 1'b0, 4'd0, 8'h00);
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end
        quiet_phase = 1'b0;

        wait_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
